@@ rtl/core/obnl_pkg.sv @@
// ---------------------------------------------------------------------------
// obnl_pkg: shared types and constants for the octree box node locator
// word formats, register indexes, reset values and control/status bundles
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obnl_pkg;

  localparam int COORD_BITS = 32;
  localparam int MIN_SIDE_BITS = 31;
  localparam int DEPTH_FIELD_BITS = 4;
  localparam int PATH_FIELD_BITS = 30;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_LEFT_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_RIGHT_X = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_TOP_Y = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_BOTTOM_Y = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_NEAR_Z = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROOT_FAR_Z = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SIDE = 3'd6;

  // reset values, 16.16 fixed point
  localparam coord_t RST_ROOT_LO = -32'sd65536;
  localparam coord_t RST_ROOT_HI = 32'sd65536;
  localparam logic [MIN_SIDE_BITS-1:0] RST_MIN_SIDE = 31'd4096;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } box_t;

  typedef struct packed {
    logic [DEPTH_FIELD_BITS-1:0] node_depth;
    logic [PATH_FIELD_BITS-1:0] octant_path;
  } node_t;

  typedef struct packed {
    coord_t root_left_x;
    coord_t root_right_x;
    coord_t root_top_y;
    coord_t root_bottom_y;
    coord_t root_near_z;
    coord_t root_far_z;
    logic [MIN_SIDE_BITS-1:0] min_side;
  } cfg_t;

  typedef struct packed {
    logic load;    // capture box and root cube
    logic centre;  // register node centres
    logic step;    // descend into chosen child
    logic emit;    // load result register
  } cmd_t;

  typedef struct packed {
    logic can_split;
    logic fit;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/obnl_ctrl.sv @@
// ---------------------------------------------------------------------------
// obnl_ctrl: descent sequencer
// steps load, centre, fit test and result hand-off for one box at a time
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obnl_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              box_valid,
  output logic             box_ready,
  output logic             node_valid,
  input  wire              node_ready,
  input  obnl_pkg::status_t status,
  output obnl_pkg::cmd_t   cmd
);
  import obnl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MID = 2'd1;
  localparam logic [1:0] S_FIT = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic node_valid_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    box_ready = 1'b0;
    node_valid_next = node_valid && !node_ready;
    case (state)
      S_IDLE: begin
        box_ready = 1'b1;
        if (box_valid) begin
          cmd.load = 1'b1;
          state_next = S_MID;
        end
      end
      S_MID: begin
        cmd.centre = 1'b1;
        state_next = status.can_split ? S_FIT : S_FIN;
      end
      S_FIT: begin
        if (status.fit) begin
          cmd.step = 1'b1;
          state_next = S_MID;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!node_valid || node_ready) begin
          cmd.emit = 1'b1;
          node_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_valid <= 1'b0;
    end else begin
      state <= state_next;
      node_valid <= node_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/obnl_datapath.sv @@
// ---------------------------------------------------------------------------
// obnl_datapath: node bounds, centres, child fit test and result register
// one halving per centre command, one child choice per step command
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obnl_datapath #(
  parameter int MAX_DEPTH = 10
) (
  input  wire              clk,
  input  obnl_pkg::cfg_t   cfg,
  input  obnl_pkg::box_t   box,
  input  obnl_pkg::cmd_t   cmd,
  output obnl_pkg::status_t status,
  output obnl_pkg::node_t  node
);
  import obnl_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int PATH_W = 3 * MAX_DEPTH;

  // axis 0 = x, 1 = y, 2 = z
  coord_t lo [3];
  coord_t hi [3];
  coord_t bmin [3];
  coord_t bmax [3];
  coord_t ctr [3];
  logic [DEPTH_W-1:0] depth;
  logic [PATH_W-1:0] path;
  logic [PATH_W-1:0] path_next;

  logic signed [COORD_BITS:0] side;
  logic side_ok;
  logic [2:0] lower_ok;
  logic [2:0] upper_ok;
  logic [7:0] fits;
  logic [2:0] chosen;
  logic [DEPTH_W+DEPTH_FIELD_BITS-1:0] depth_ext;
  logic [PATH_W+PATH_FIELD_BITS-1:0] path_ext;

  // x side against twice the minimum side
  always_comb begin
    side = {hi[0][COORD_BITS-1], hi[0]} - {lo[0][COORD_BITS-1], lo[0]};
    side_ok = $signed({side[COORD_BITS], side}) >=
              $signed({2'b00, cfg.min_side, 1'b0});
  end

  // half tests per axis against the registered centre
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lower_ok[k] = (bmin[k] >= lo[k]) && (bmax[k] <= ctr[k]);
      upper_ok[k] = (bmin[k] >= ctr[k]) && (bmax[k] <= hi[k]);
    end
    for (int i = 0; i < 8; i++) begin
      fits[i] = (i[0] ? upper_ok[0] : lower_ok[0]) &&
                (i[1] ? lower_ok[1] : upper_ok[1]) &&
                (i[2] ? upper_ok[2] : lower_ok[2]);
    end
    chosen = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (fits[i]) begin
        chosen = 3'(i);
      end
    end
  end

  // status back to the sequencer
  always_comb begin
    status.can_split = side_ok && (depth != DEPTH_W'(MAX_DEPTH));
    status.fit = |fits;
  end

  always_comb begin
    path_next = path;
    for (int l = 0; l < MAX_DEPTH; l++) begin
      if (depth == DEPTH_W'(l)) begin
        path_next[3*l +: 3] = chosen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo[0] <= cfg.root_left_x;
      hi[0] <= cfg.root_right_x;
      lo[1] <= cfg.root_bottom_y;
      hi[1] <= cfg.root_top_y;
      lo[2] <= cfg.root_near_z;
      hi[2] <= cfg.root_far_z;
      bmin[0] <= box.box_min_x;
      bmin[1] <= box.box_min_y;
      bmin[2] <= box.box_min_z;
      bmax[0] <= box.box_max_x;
      bmax[1] <= box.box_max_y;
      bmax[2] <= box.box_max_z;
      depth <= '0;
      path <= '0;
    end
    if (cmd.centre) begin
      // floor of the mean, exact in one extra bit
      for (int k = 0; k < 3; k++) begin
        ctr[k] <= coord_t'(({lo[k][COORD_BITS-1], lo[k]} +
                            {hi[k][COORD_BITS-1], hi[k]}) >>> 1);
      end
    end
    if (cmd.step) begin
      if (chosen[0]) lo[0] <= ctr[0];
      else hi[0] <= ctr[0];
      // y bit set picks the lower half
      if (chosen[1]) hi[1] <= ctr[1];
      else lo[1] <= ctr[1];
      if (chosen[2]) lo[2] <= ctr[2];
      else hi[2] <= ctr[2];
      depth <= depth + 1'b1;
      path <= path_next;
    end
    if (cmd.emit) begin
      node.node_depth <= depth_ext[DEPTH_FIELD_BITS-1:0];
      node.octant_path <= path_ext[PATH_FIELD_BITS-1:0];
    end
  end

  assign depth_ext = {{DEPTH_FIELD_BITS{1'b0}}, depth};
  assign path_ext = {{PATH_FIELD_BITS{1'b0}}, path};

endmodule

`default_nettype wire

@@ rtl/core/octree_box_node_locate.sv @@
// descent: from box accept, each level passes the centre and fit test states; the
//   search ends on a failed split test or a failed fit test, then hands off the result
// throughput: one box at a time; a new box is taken only in idle, after the result of
//   the last one is handed off, each level reusing the single compare datapath
// reset: synchronous active-high rst returns the sequencer to idle, drops node_valid
//   and loads the root cube registers with -1.0 to 1.0 per axis, min_side with 4096
// ---------------------------------------------------------------------------
// octree_box_node_locate: enclosing octree node search for one box
// descends from the configured root cube and returns depth and octant path
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module octree_box_node_locate #(
  parameter int MAX_DEPTH = 10
) (
  input  wire                                       clk,
  input  wire                                       rst,
  // box word in
  input  wire                                       box_valid,
  output logic                                      box_ready,
  input  obnl_pkg::box_t                            box,
  // node word out
  output logic                                      node_valid,
  input  wire                                       node_ready,
  output obnl_pkg::node_t                           node,
  // register writes
  input  wire                                       cfg_we,
  input  wire [obnl_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  wire [obnl_pkg::COORD_BITS-1:0]            cfg_data
);
  import obnl_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  status_t status;

  // configuration registers; the user must write them only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_left_x <= RST_ROOT_LO;
      cfg.root_right_x <= RST_ROOT_HI;
      cfg.root_top_y <= RST_ROOT_HI;
      cfg.root_bottom_y <= RST_ROOT_LO;
      cfg.root_near_z <= RST_ROOT_LO;
      cfg.root_far_z <= RST_ROOT_HI;
      cfg.min_side <= RST_MIN_SIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROOT_LEFT_X:   cfg.root_left_x <= cfg_data;
        REG_ROOT_RIGHT_X:  cfg.root_right_x <= cfg_data;
        REG_ROOT_TOP_Y:    cfg.root_top_y <= cfg_data;
        REG_ROOT_BOTTOM_Y: cfg.root_bottom_y <= cfg_data;
        REG_ROOT_NEAR_Z:   cfg.root_near_z <= cfg_data;
        REG_ROOT_FAR_Z:    cfg.root_far_z <= cfg_data;
        REG_MIN_SIDE:      cfg.min_side <= cfg_data[MIN_SIDE_BITS-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // sequencer: idle, centre, fit test, hand-off
  obnl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .box_valid  (box_valid),
    .box_ready  (box_ready),
    .node_valid (node_valid),
    .node_ready (node_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // bounds, centres, compares and result register
  obnl_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .cfg    (cfg),
    .box    (box),
    .cmd    (cmd),
    .status (status),
    .node   (node)
  );

`ifndef SYNTHESIS
  // one box in flight: no second accept straight after the first
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (box_valid && box_ready) |=> !box_ready)
    else $error("box accepted while descent busy");

  // a hand-off always shows a result in the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> node_valid)
    else $error("result lost at hand-off");

  // hand-off never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!node_valid || node_ready))
    else $error("pending result overwritten");

  // reported depth stays within the limit
  a_depth_limit: assert property (@(posedge clk) disable iff (rst)
    node_valid |-> ((MAX_DEPTH > 15) || (node.node_depth <= MAX_DEPTH)))
    else $error("depth beyond limit");
`endif

endmodule

`default_nettype wire

@@ bench/obnl_checker.sv @@
// ---------------------------------------------------------------------------
// obnl_checker: scoreboard for the octree box node locator
// watches the box, node and register ports, works out the enclosing node of
// every accepted box and compares each node word against the oldest one
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module obnl_checker #(
  parameter int MAX_DEPTH = 10
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                box_valid,
  input  wire                                box_ready,
  input  obnl_pkg::box_t                     box,
  input  wire                                node_valid,
  input  wire                                node_ready,
  input  obnl_pkg::node_t                    node,
  input  wire                                cfg_we,
  input  wire [obnl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [obnl_pkg::COORD_BITS-1:0]     cfg_data,
  output int                                 failures,
  output int                                 outstanding,
  output int                                 nodes_checked,
  output int                                 deepest,
  output int                                 full_depth_hits
);

  import obnl_pkg::*;

  cfg_t  cfg_now;
  node_t predicted_nodes[$];

  // walk down from the root cube, first enclosing child wins at each level
  function automatic node_t locate_node(input box_t b, input cfg_t r);
    logic signed [63:0] lo [0:2];
    logic signed [63:0] hi [0:2];
    logic signed [63:0] bmin [0:2];
    logic signed [63:0] bmax [0:2];
    logic signed [63:0] ctr [0:2];
    logic signed [63:0] nlo [0:2];
    logic signed [63:0] nhi [0:2];
    logic signed [63:0] a_lo, a_hi, twice_min;
    logic [63:0] path;
    int level, child, pick, k;
    logic upper, fits, done;
    node_t res;
    lo[0] = $signed(r.root_left_x);
    hi[0] = $signed(r.root_right_x);
    lo[1] = $signed(r.root_bottom_y);
    hi[1] = $signed(r.root_top_y);
    lo[2] = $signed(r.root_near_z);
    hi[2] = $signed(r.root_far_z);
    bmin[0] = $signed(b.box_min_x);
    bmin[1] = $signed(b.box_min_y);
    bmin[2] = $signed(b.box_min_z);
    bmax[0] = $signed(b.box_max_x);
    bmax[1] = $signed(b.box_max_y);
    bmax[2] = $signed(b.box_max_z);
    twice_min = $signed({32'd0, r.min_side, 1'b0});
    path = '0;
    level = 0;
    done = 1'b0;
    while (level < MAX_DEPTH && !done) begin
      if (hi[0] - lo[0] < twice_min) begin
        done = 1'b1;
      end else begin
        for (k = 0; k < 3; k++) ctr[k] = (lo[k] + hi[k]) >>> 1;
        pick = -1;
        for (child = 0; child < 8 && pick < 0; child++) begin
          fits = 1'b1;
          for (k = 0; k < 3; k++) begin
            upper = ((child >> k) & 1) != 0;
            // y bit picks the lower half
            if (k == 1) upper = !upper;
            a_lo = upper ? ctr[k] : lo[k];
            a_hi = upper ? hi[k] : ctr[k];
            if (bmin[k] < a_lo || bmax[k] > a_hi) fits = 1'b0;
            nlo[k] = a_lo;
            nhi[k] = a_hi;
          end
          if (fits) pick = child;
        end
        if (pick < 0) begin
          done = 1'b1;
        end else begin
          for (k = 0; k < 3; k++) begin
            lo[k] = nlo[k];
            hi[k] = nhi[k];
          end
          path = path | (64'(pick) << (3 * level));
          level++;
        end
      end
    end
    res.node_depth = 4'(level);
    res.octant_path = path[PATH_FIELD_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    node_t want;
    if (rst) begin
      predicted_nodes.delete();
      cfg_now.root_left_x = RST_ROOT_LO;
      cfg_now.root_right_x = RST_ROOT_HI;
      cfg_now.root_top_y = RST_ROOT_HI;
      cfg_now.root_bottom_y = RST_ROOT_LO;
      cfg_now.root_near_z = RST_ROOT_LO;
      cfg_now.root_far_z = RST_ROOT_HI;
      cfg_now.min_side = RST_MIN_SIDE;
      failures = 0;
      nodes_checked = 0;
      deepest = 0;
      full_depth_hits = 0;
      outstanding <= 0;
    end else begin
      // result side first, so a stray word never meets this edge's box
      if (node_valid && node_ready) begin
        if (predicted_nodes.size() == 0) begin
          $error("node word with no box outstanding: depth %0d path %0h",
                 node.node_depth, node.octant_path);
          failures++;
        end else begin
          want = predicted_nodes.pop_front();
          if (node.node_depth !== want.node_depth) begin
            $error("node_depth mismatch: expected %0d, actual %0d",
                   want.node_depth, node.node_depth);
            failures++;
          end
          if (node.octant_path !== want.octant_path) begin
            $error("octant_path mismatch: expected %0h, actual %0h",
                   want.octant_path, node.octant_path);
            failures++;
          end
          nodes_checked++;
          if (int'(want.node_depth) > deepest) deepest = want.node_depth;
          if (int'(want.node_depth) == MAX_DEPTH) full_depth_hits++;
        end
      end
      if (box_valid && box_ready)
        predicted_nodes = {predicted_nodes, locate_node(box, cfg_now)};
      if (cfg_we) begin
        case (cfg_index)
          REG_ROOT_LEFT_X:   cfg_now.root_left_x = cfg_data;
          REG_ROOT_RIGHT_X:  cfg_now.root_right_x = cfg_data;
          REG_ROOT_TOP_Y:    cfg_now.root_top_y = cfg_data;
          REG_ROOT_BOTTOM_Y: cfg_now.root_bottom_y = cfg_data;
          REG_ROOT_NEAR_Z:   cfg_now.root_near_z = cfg_data;
          REG_ROOT_FAR_Z:    cfg_now.root_far_z = cfg_data;
          REG_MIN_SIDE:      cfg_now.min_side = cfg_data[MIN_SIDE_BITS-1:0];
          default: ;
        endcase
      end
      outstanding <= predicted_nodes.size();
    end
  end

endmodule

@@ bench/tb_octree_box_node_locate.sv @@
// ---------------------------------------------------------------------------
// tb_octree_box_node_locate: top of the octree box node locator bench
// drives boxes and register settings with random gaps and stalls; the
// checker beside the block predicts every node word and counts mismatches
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_octree_box_node_locate;

  import obnl_pkg::*;

  localparam int MAX_DEPTH = 10;
  // serial search, one box at a time
  localparam int SETTLE = 2 * MAX_DEPTH + 12;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam coord_t ONE = 32'sd65536;

  logic clk;
  logic rst = 1'b1;

  logic  box_valid = 1'b0;
  logic  box_ready;
  box_t  box_word = '0;
  logic  node_valid;
  logic  node_ready = 1'b0;
  node_t node_word;
  logic  cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0]     cfg_data = '0;

  int failures, outstanding, nodes_checked, deepest, full_depth_hits;

  // stimulus side bookkeeping
  cfg_t root_now;
  int   boxes_sent = 0;
  int   settings_loaded = 0;
  int   cycle_count = 0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  octree_box_node_locate #(.MAX_DEPTH(MAX_DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .box_valid  (box_valid),
    .box_ready  (box_ready),
    .box        (box_word),
    .node_valid (node_valid),
    .node_ready (node_ready),
    .node       (node_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  obnl_checker #(.MAX_DEPTH(MAX_DEPTH)) node_check (
    .clk             (clk),
    .rst             (rst),
    .box_valid       (box_valid),
    .box_ready       (box_ready),
    .box             (box_word),
    .node_valid      (node_valid),
    .node_ready      (node_ready),
    .node            (node_word),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .outstanding     (outstanding),
    .nodes_checked   (nodes_checked),
    .deepest         (deepest),
    .full_depth_hits (full_depth_hits)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timed out after %0d cycles, %0d node words still due", cycle_count,
             outstanding);
      $display("tb_octree_box_node_locate failed");
      $finish;
    end
  end

  // node sink: random stalls, a calm stretch, and one long hold-off so the
  // block backs up and stops taking boxes
  initial begin : sink
    int held;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        node_ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        node_ready <= rx_calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // uniform value in [0, bound], bound below 2^33
  function automatic longint rand_upto(input longint bound);
    longint unsigned r;
    if (bound <= 0) return 0;
    r = {$urandom(), $urandom()};
    return longint'(r % longint'(bound + 1));
  endfunction

  // one axis of a box inside [lo, hi], sized for roughly t levels of descent
  function automatic void pick_range(input longint lo, input longint hi, input int t,
                                     output coord_t a, output coord_t z);
    longint span, sz, pos, tmp;
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    span = hi - lo;
    sz = rand_upto(span >>> (t + 1));
    if ($urandom_range(9) == 0) sz = 0;
    pos = lo + rand_upto(span - sz);
    // snap onto the node bounds now and then, tests are inclusive
    case ($urandom_range(7))
      0: pos = lo;
      1: pos = hi - sz;
      default: ;
    endcase
    a = coord_t'(pos);
    z = coord_t'(pos + sz);
  endfunction

  // mostly boxes inside the current root, some noise and broken boxes
  function automatic box_t random_box();
    box_t b;
    longint lo [0:2];
    longint hi [0:2];
    coord_t a [0:2];
    coord_t z [0:2];
    coord_t tmp;
    int mode, t, k, sel;
    lo[0] = root_now.root_left_x;
    hi[0] = root_now.root_right_x;
    lo[1] = root_now.root_bottom_y;
    hi[1] = root_now.root_top_y;
    lo[2] = root_now.root_near_z;
    hi[2] = root_now.root_far_z;
    mode = $urandom_range(99);
    t = $urandom_range(11);
    for (k = 0; k < 3; k++) pick_range(lo[k], hi[k], t, a[k], z[k]);
    if (mode >= 90) begin
      sel = $urandom_range(2);
      if ($urandom_range(1) == 1) begin
        tmp = a[sel];
        a[sel] = z[sel];
        z[sel] = tmp;
      end else begin
        a[sel] = a[sel] - coord_t'($urandom_range(65536));
        z[sel] = z[sel] + coord_t'($urandom_range(65536));
      end
    end
    b.box_min_x = a[0];
    b.box_min_y = a[1];
    b.box_min_z = a[2];
    b.box_max_x = z[0];
    b.box_max_y = z[1];
    b.box_max_z = z[2];
    if (mode >= 75 && mode < 90)
      b = box_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    return b;
  endfunction

  function automatic box_t mk_box(input coord_t x0, input coord_t y0, input coord_t z0,
                                  input coord_t x1, input coord_t y1, input coord_t z1);
    box_t b;
    b.box_min_x = x0;
    b.box_min_y = y0;
    b.box_min_z = z0;
    b.box_max_x = x1;
    b.box_max_y = y1;
    b.box_max_z = z1;
    return b;
  endfunction

  function automatic cfg_t random_root();
    cfg_t s;
    longint lo, hi;
    int k;
    for (k = 0; k < 3; k++) begin
      lo = longint'($signed($urandom()));
      hi = lo + (rand_upto(64'sd2147483647 - lo) >>> $urandom_range(31));
      case (k)
        0: begin
          s.root_left_x = coord_t'(lo);
          s.root_right_x = coord_t'(hi);
          s.min_side = MIN_SIDE_BITS'((hi - lo) >>> $urandom_range(1, 14));
        end
        1: begin
          s.root_bottom_y = coord_t'(lo);
          s.root_top_y = coord_t'(hi);
        end
        default: begin
          s.root_near_z = coord_t'(lo);
          s.root_far_z = coord_t'(hi);
        end
      endcase
    end
    return s;
  endfunction

  // one box word; an idle gap may come first, valid holds until accepted
  task automatic send_box(input box_t b);
    if (!tx_calm && $urandom_range(99) < 33) begin
      box_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 33) @(posedge clk);
    end
    box_valid <= 1'b1;
    box_word <= b;
    do @(posedge clk); while (!box_ready);
    boxes_sent++;
  endtask

  // block idle: nothing due and the search has had time to wind down
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_setting(input cfg_t s, input bit poke_unused);
    logic [COORD_BITS-1:0] words [0:7];
    int i;
    wait_idle();
    words[REG_ROOT_LEFT_X] = s.root_left_x;
    words[REG_ROOT_RIGHT_X] = s.root_right_x;
    words[REG_ROOT_TOP_Y] = s.root_top_y;
    words[REG_ROOT_BOTTOM_Y] = s.root_bottom_y;
    words[REG_ROOT_NEAR_Z] = s.root_near_z;
    words[REG_ROOT_FAR_Z] = s.root_far_z;
    // top bit of min_side is dropped by the block
    words[REG_MIN_SIDE] = {1'($urandom_range(1)), s.min_side};
    words[REG_UNUSED] = $urandom();
    for (i = 0; i < 8; i++) begin
      if (i != REG_UNUSED || poke_unused) begin
        cfg_we <= 1'b1;
        cfg_index <= CFG_INDEX_BITS'(i);
        cfg_data <= words[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    root_now = s;
    settings_loaded++;
  endtask

  task automatic run_random(input int n, input int calm_lo, input int calm_hi,
                            input int hold_at);
    int i;
    for (i = 0; i < n; i++) begin
      tx_calm = (i >= calm_lo && i < calm_hi);
      if (i == calm_hi) rx_calm <= 1'b0;
      else if (i == calm_lo) rx_calm <= 1'b1;
      if (i == hold_at) hold_off_req <= 1'b1;
      send_box(random_box());
    end
    tx_calm = 1'b0;
    box_valid <= 1'b0;
    rx_calm <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t s;
    int c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset root: -1.0 to 1.0 per axis, min side 4096
    root_now.root_left_x = RST_ROOT_LO;
    root_now.root_right_x = RST_ROOT_HI;
    root_now.root_top_y = RST_ROOT_HI;
    root_now.root_bottom_y = RST_ROOT_LO;
    root_now.root_near_z = RST_ROOT_LO;
    root_now.root_far_z = RST_ROOT_HI;
    root_now.min_side = RST_MIN_SIDE;
    settings_loaded = 1;

    // directed: whole root, centre point, corner chains
    send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    send_box(mk_box(ONE, -ONE, ONE, ONE, -ONE, ONE));
    send_box(mk_box(-ONE, ONE, -ONE, -ONE, ONE, -ONE));
    // a point in every octant
    for (c = 0; c < 8; c++) begin
      send_box(mk_box(c[0] ? 30000 : -30000, c[1] ? -30000 : 30000, c[2] ? 30000 : -30000,
                      c[0] ? 30000 : -30000, c[1] ? -30000 : 30000, c[2] ? 30000 : -30000));
    end
    // outside the root, partly outside, reversed box
    send_box(mk_box(2 * ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE));
    send_box(mk_box(-2 * ONE, 1000, 1000, 2000, 2000, 2000));
    send_box(mk_box(20000, 20000, 20000, 10000, 10000, 10000));
    // field extremes
    send_box(mk_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_box(box_t'({6{32'h80000000}}));
    send_box(box_t'({6{32'h7fffffff}}));
    // straddles the y centre only, then exactly one child's bounds
    send_box(mk_box(1000, -500, 1000, 2000, 500, 2000));
    send_box(mk_box(0, -ONE, 0, ONE, 0, ONE));
    run_random(240, 100, 180, -1);

    // widest root with the finest split: full depth reachable
    s.root_left_x = 32'sh80000000;
    s.root_right_x = 32'sh7fffffff;
    s.root_top_y = 32'sh7fffffff;
    s.root_bottom_y = 32'sh80000000;
    s.root_near_z = 32'sh80000000;
    s.root_far_z = 32'sh7fffffff;
    s.min_side = 31'd1;
    load_setting(s, 1'b1);
    run_random(240, 40, 120, 40);

    // largest min side: only the widest root splits at all
    s.min_side = 31'h7fffffff;
    load_setting(s, 1'b0);
    run_random(80, 0, 0, -1);

    // zero min side on a small cube
    s.root_left_x = 0;
    s.root_right_x = 1023;
    s.root_top_y = 1023;
    s.root_bottom_y = 0;
    s.root_near_z = 0;
    s.root_far_z = 1023;
    s.min_side = 31'd0;
    load_setting(s, 1'b1);
    run_random(150, 0, 0, -1);

    // reversed root on every axis
    s.root_left_x = ONE;
    s.root_right_x = -ONE;
    s.root_top_y = -ONE;
    s.root_bottom_y = ONE;
    s.root_near_z = ONE;
    s.root_far_z = -ONE;
    s.min_side = MIN_SIDE_BITS'($urandom());
    load_setting(s, 1'b0);
    run_random(70, 0, 0, -1);

    for (c = 0; c < 3; c++) begin
      load_setting(random_root(), c == 1);
      run_random(130, 0, 0, -1);
    end

    // drain, then a tail for any stray node word
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d boxes over %0d root settings, %0d node words checked",
             boxes_sent, settings_loaded, nodes_checked);
    $display("deepest node at level %0d, %0d nodes at full depth", deepest,
             full_depth_hits);
    if (failures == 0) begin
      $display("tb_octree_box_node_locate passed");
    end else begin
      $display("tb_octree_box_node_locate failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/obnl_pkg.sv
rtl/core/obnl_ctrl.sv
rtl/core/obnl_datapath.sv
rtl/core/octree_box_node_locate.sv
bench/obnl_checker.sv
bench/tb_octree_box_node_locate.sv
